// File: sv/ssp_pkg.sv
// Shared constants, field widths and types of the shortest-path core.
package ssp_pkg;

  // Field widths of the stream items and registers
  localparam int CMD_W = 2;
  localparam int VTX_W = 4;
  localparam int WGT_W = 16;
  localparam int CNT_W = 5;

  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Commands
  localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RUN   = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_COUNT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNREACHABLE  = 4'd1;

  // Reset values
  localparam logic [CNT_W-1:0] VERTEX_COUNT_RST = 5'd16;
  localparam logic [WGT_W-1:0] UNREACHABLE_RST  = 16'd99;

  // Parameter defaults
  localparam int DEF_MAX_VERTICES = 16;
  localparam int DEF_WEIGHT_BITS  = 16;

  // Weight matrix control
  typedef struct packed {
    logic wr;
    logic clr;
  } mat_cmd_t;

endpackage

// File: sv/ssp_matrix.sv
// Weight matrix memory with per-cell valid bits and a latched fill value for clears.
module ssp_matrix #(
  parameter int MAX_VERTICES = ssp_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = ssp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssp_pkg::mat_cmd_t                   cmd_i,
  input  logic [2*$clog2(MAX_VERTICES)-1:0]   waddr_i,
  input  logic [WEIGHT_BITS-1:0]              wdata_i,
  input  logic [WEIGHT_BITS-1:0]              fill_i,
  input  logic [2*$clog2(MAX_VERTICES)-1:0]   raddr_i,
  output logic [WEIGHT_BITS-1:0]              rdata_o
);
  import ssp_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int ADR_W = 2 * IDX_W;
  localparam int DEPTH = 2 ** ADR_W;

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [DEPTH-1:0]       valid_q;
  logic [WEIGHT_BITS-1:0] fill_q;
  logic [WEIGHT_BITS-1:0] rd_q;
  logic                   rd_valid_q;
  logic                   rd_diag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  // A cell that was not written since the last clear reads as zero on the diagonal and as the clear pattern elsewhere
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      fill_q     <= WEIGHT_BITS'(UNREACHABLE_RST);
      rd_valid_q <= 1'b0;
      rd_diag_q  <= 1'b0;
    end else begin
      if (cmd_i.clr) begin
        valid_q <= '0;
        fill_q  <= fill_i;
      end else if (cmd_i.wr) begin
        valid_q[waddr_i] <= 1'b1;
      end
      rd_valid_q <= valid_q[raddr_i];
      rd_diag_q  <= (raddr_i[ADR_W-1:IDX_W] == raddr_i[IDX_W-1:0]);
    end
  end

  always_comb begin
    if (rd_valid_q) begin
      rdata_o = rd_q;
    end else if (rd_diag_q) begin
      rdata_o = '0;
    end else begin
      rdata_o = fill_q;
    end
  end

endmodule

// File: sv/ssp_dist_ram.sv
// Distance store: one write port, one registered read port.
module ssp_dist_ram #(
  parameter int MAX_VERTICES = ssp_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = ssp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                              clk_i,
  input  logic                              we_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]   waddr_i,
  input  logic [WEIGHT_BITS-1:0]            wdata_i,
  input  logic [$clog2(MAX_VERTICES)-1:0]   raddr_i,
  output logic [WEIGHT_BITS-1:0]            rdata_o
);
  import ssp_pkg::*;

  localparam int DEPTH = 2 ** $clog2(MAX_VERTICES);

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [WEIGHT_BITS-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q <= mem[raddr_i];
  end

  assign rdata_o = rd_q;

endmodule

// File: sv/ssp_alu.sv
// Shared add-and-compare unit: take when cur exceeds base plus addend and, with the edge check on, addend is not inf.
module ssp_alu #(
  parameter int WEIGHT_BITS = ssp_pkg::DEF_WEIGHT_BITS
) (
  input  logic [WEIGHT_BITS-1:0] base_i,
  input  logic [WEIGHT_BITS-1:0] addend_i,
  input  logic [WEIGHT_BITS-1:0] cur_i,
  input  logic [WEIGHT_BITS-1:0] inf_i,
  input  logic                   check_edge_i,
  output logic [WEIGHT_BITS:0]   sum_o,
  output logic                   take_o
);
  import ssp_pkg::*;

  logic is_edge;

  // Full-width sum, no wrap
  assign sum_o   = {1'b0, base_i} + {1'b0, addend_i};
  assign is_edge = !check_edge_i || (addend_i != inf_i);
  assign take_o  = is_edge && ({1'b0, cur_i} > sum_o);

endmodule

// File: sv/single_source_shortest_path_core.sv
// Shortest-path core: sequencer over the weight matrix, distance store and shared unit.
//
// Holds a MAX_VERTICES square weight matrix (diagonal 0, other cells the
// unreachable value) and answers three commands on the input stream: write one
// edge weight, clear the matrix, or run Dijkstra from vertex 0. Writes and
// clears do not leave the idle state, so the core stays ready for items; a
// clear is immediate because every cell carries a valid bit, so there is no
// clearing pass after reset or clear. A run over n vertices is sequenced
// through one add-and-compare unit, a single-read weight memory and a
// single-read distance memory, each element visited in a read state and then
// a state that uses the data: it loads the first row, then runs up to n-1
// rounds of minimum scan plus relaxation, then emits the distances, waiting
// out any output stall. The core does not accept items during a run. One
// result per vertex leaves in vertex order with tlast on the final vertex.
module single_source_shortest_path_core #(
  parameter int MAX_VERTICES = ssp_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = ssp_pkg::DEF_WEIGHT_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // fields from bit 0: command[1:0], row[5:2], col[9:6], weight[25:10], zero pad
  input  logic [ssp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // fields from bit 0: vertex[3:0], distance[19:4], zero pad
  output logic [ssp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  output logic                             m_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ssp_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [ssp_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ssp_pkg::*;

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int ADR_W = 2 * IDX_W;

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_INIT_RD  = 4'd1;
  localparam logic [3:0] ST_INIT_WR  = 4'd2;
  localparam logic [3:0] ST_SCAN_RD  = 4'd3;
  localparam logic [3:0] ST_SCAN_CMP = 4'd4;
  localparam logic [3:0] ST_REL_RD   = 4'd5;
  localparam logic [3:0] ST_REL_CMP  = 4'd6;
  localparam logic [3:0] ST_OUT_RD   = 4'd7;
  localparam logic [3:0] ST_OUT_SHOW = 4'd8;

  // Input fields
  logic [CMD_W-1:0] in_cmd;
  logic [VTX_W-1:0] in_row;
  logic [VTX_W-1:0] in_col;
  logic [WGT_W-1:0] in_weight;

  assign in_cmd    = s_axis_tdata[1:0];
  assign in_row    = s_axis_tdata[5:2];
  assign in_col    = s_axis_tdata[9:6];
  assign in_weight = s_axis_tdata[25:10];

  logic [3:0]              state_q, state_d;
  logic [IDX_W-1:0]        j_q, j_d;
  logic [IDX_W-1:0]        u_q, u_d;
  logic [IDX_W-1:0]        round_q, round_d;
  logic [IDX_W-1:0]        n_m1_q, n_m1_d;
  logic [WEIGHT_BITS-1:0]  best_q, best_d;
  logic                    found_q, found_d;
  logic [MAX_VERTICES-1:0] visited_q, visited_d;
  logic [CNT_W-1:0]        vcount_q;
  logic [WGT_W-1:0]        unreach_q;

  logic [WEIGHT_BITS-1:0] inf;
  logic [IDX_W-1:0]       n_m1_cmd;
  logic                   in_acc;
  logic                   in_range;
  logic                   j_last;

  mat_cmd_t               mat_cmd;
  logic [ADR_W-1:0]       mat_waddr;
  logic [ADR_W-1:0]       mat_raddr;
  logic [WEIGHT_BITS-1:0] mat_rdata;

  logic                   dist_we;
  logic [WEIGHT_BITS-1:0] dist_wdata;
  logic [WEIGHT_BITS-1:0] dist_rdata;

  logic [WEIGHT_BITS-1:0] alu_base;
  logic [WEIGHT_BITS-1:0] alu_addend;
  logic [WEIGHT_BITS-1:0] alu_cur;
  logic                   alu_check;
  logic [WEIGHT_BITS:0]   alu_sum;
  logic                   alu_take;
  logic                   scan_take;

  assign inf      = WEIGHT_BITS'(unreach_q);
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign in_range = (int'(in_row) < MAX_VERTICES) && (int'(in_col) < MAX_VERTICES);
  assign j_last   = (j_q == n_m1_q);

  // Vertex count of zero acts as one, above the matrix size acts as the size
  always_comb begin
    if (vcount_q == '0) begin
      n_m1_cmd = '0;
    end else if (int'(vcount_q) > MAX_VERTICES) begin
      n_m1_cmd = IDX_W'(MAX_VERTICES - 1);
    end else begin
      n_m1_cmd = IDX_W'(vcount_q - 1'b1);
    end
  end

  // Configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vcount_q  <= VERTEX_COUNT_RST;
      unreach_q <= UNREACHABLE_RST;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == REG_VERTEX_COUNT) begin
        vcount_q <= cfg_data_i[CNT_W-1:0];
      end else if (cfg_index_i == REG_UNREACHABLE) begin
        unreach_q <= cfg_data_i;
      end
    end
  end

  // Memory hookup
  assign mat_cmd.wr = in_acc && (in_cmd == CMD_WRITE) && in_range;
  assign mat_cmd.clr = in_acc && (in_cmd == CMD_CLEAR);
  assign mat_waddr  = {IDX_W'(in_row), IDX_W'(in_col)};
  assign mat_raddr  = {((state_q == ST_REL_RD) ? u_q : {IDX_W{1'b0}}), j_q};

  ssp_matrix #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (mat_cmd),
    .waddr_i (mat_waddr),
    .wdata_i (WEIGHT_BITS'(in_weight)),
    .fill_i  (inf),
    .raddr_i (mat_raddr),
    .rdata_o (mat_rdata)
  );

  ssp_dist_ram #(
    .MAX_VERTICES (MAX_VERTICES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_dist (
    .clk_i   (clk_i),
    .we_i    (dist_we),
    .waddr_i (j_q),
    .wdata_i (dist_wdata),
    .raddr_i (j_q),
    .rdata_o (dist_rdata)
  );

  // Scan compares best > dist[j]; relax compares dist[j] > dist[u] + w
  always_comb begin
    if (state_q == ST_SCAN_CMP) begin
      alu_base   = dist_rdata;
      alu_addend = '0;
      alu_cur    = best_q;
      alu_check  = 1'b0;
    end else begin
      alu_base   = best_q;
      alu_addend = mat_rdata;
      alu_cur    = dist_rdata;
      alu_check  = 1'b1;
    end
  end

  ssp_alu #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_alu (
    .base_i       (alu_base),
    .addend_i     (alu_addend),
    .cur_i        (alu_cur),
    .inf_i        (inf),
    .check_edge_i (alu_check),
    .sum_o        (alu_sum),
    .take_o       (alu_take)
  );

  assign scan_take = !visited_q[j_q] && alu_take;

  always_comb begin
    if (state_q == ST_INIT_WR) begin
      dist_we    = 1'b1;
      dist_wdata = (j_q == '0) ? '0 : mat_rdata;
    end else begin
      dist_we    = (state_q == ST_REL_CMP) && alu_take;
      dist_wdata = alu_sum[WEIGHT_BITS-1:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d   = state_q;
    j_d       = j_q;
    u_d       = u_q;
    round_d   = round_q;
    n_m1_d    = n_m1_q;
    best_d    = best_q;
    found_d   = found_q;
    visited_d = visited_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (in_cmd == CMD_RUN)) begin
          n_m1_d  = n_m1_cmd;
          j_d     = '0;
          state_d = ST_INIT_RD;
        end
      end
      ST_INIT_RD: begin
        state_d = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        if (j_last) begin
          visited_d    = '0;
          visited_d[0] = 1'b1;
          round_d      = '0;
          best_d       = inf;
          found_d      = 1'b0;
          j_d          = '0;
          state_d      = (n_m1_q == '0) ? ST_OUT_RD : ST_SCAN_RD;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_INIT_RD;
        end
      end
      ST_SCAN_RD: begin
        state_d = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (scan_take) begin
          best_d  = dist_rdata;
          u_d     = j_q;
          found_d = 1'b1;
        end
        if (j_last) begin
          j_d = '0;
          // Stop relaxing when nothing unvisited is reachable
          if (found_d) begin
            visited_d[u_d] = 1'b1;
            state_d        = ST_REL_RD;
          end else begin
            state_d = ST_OUT_RD;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_SCAN_RD;
        end
      end
      ST_REL_RD: begin
        state_d = ST_REL_CMP;
      end
      ST_REL_CMP: begin
        if (j_last) begin
          j_d = '0;
          if (({1'b0, round_q} + 1'b1) < {1'b0, n_m1_q}) begin
            round_d = round_q + 1'b1;
            best_d  = inf;
            found_d = 1'b0;
            state_d = ST_SCAN_RD;
          end else begin
            state_d = ST_OUT_RD;
          end
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_REL_RD;
        end
      end
      ST_OUT_RD: begin
        state_d = ST_OUT_SHOW;
      end
      ST_OUT_SHOW: begin
        if (m_axis_tready) begin
          if (j_last) begin
            state_d = ST_IDLE;
          end else begin
            j_d     = j_q + 1'b1;
            state_d = ST_OUT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      j_q       <= '0;
      u_q       <= '0;
      round_q   <= '0;
      n_m1_q    <= '0;
      best_q    <= '0;
      found_q   <= 1'b0;
      visited_q <= '0;
    end else begin
      state_q   <= state_d;
      j_q       <= j_d;
      u_q       <= u_d;
      round_q   <= round_d;
      n_m1_q    <= n_m1_d;
      best_q    <= best_d;
      found_q   <= found_d;
      visited_q <= visited_d;
    end
  end

  // Stream ports; the read register holds the distance while the item waits
  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = (state_q == ST_OUT_SHOW);
  assign m_axis_tlast  = j_last;
  assign m_axis_tdata  = {{(OUT_TDATA_W - VTX_W - WGT_W){1'b0}},
                          WGT_W'(dist_rdata), VTX_W'(j_q)};

endmodule
